/* hw/rtl/led_matrix_rotating_row_scanner_macros.svh */
// Assertion macros shared by the LED matrix row scanner RTL.
`ifndef LED_MATRIX_ROTATING_ROW_SCANNER_MACROS_SVH
`define LED_MATRIX_ROTATING_ROW_SCANNER_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check, masked while reset is asserted.
`define LMRRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LMRRS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LMRRS_ASSERT(label, prop, msg)
`define LMRRS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* hw/rtl/lmrrs_pkg.sv */
// Types, constants and codes shared by the LED matrix row scanner modules.
package lmrrs_pkg;

	// Matrix geometry
	localparam int SIDE    = 8;
	localparam int NUM_PIX = SIDE * SIDE;
	localparam int COORD_W = (SIDE > 2) ? $clog2(SIDE) : 1;
	localparam int IDX_W   = $clog2(NUM_PIX);
	localparam int PIX_W   = 2;

	localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(SIDE - 1);
	localparam logic [IDX_W-1:0]   SIDE_IDX   = IDX_W'(SIDE);

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SCAN  = 1'b1;

	// Port select codes
	localparam logic PORT_DATA = 1'b0;
	localparam logic PORT_CTRL = 1'b1;

	// Kind of port write requested by the controller
	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] EMIT_BLANK = 3'd0;
	localparam logic [KIND_W-1:0] EMIT_DATA  = 3'd1;
	localparam logic [KIND_W-1:0] EMIT_CLKLO = 3'd2;
	localparam logic [KIND_W-1:0] EMIT_CLKHI = 3'd3;
	localparam logic [KIND_W-1:0] EMIT_SEL   = 3'd4;

	// Control shadow bit positions
	localparam int SH_CLK  = 0;
	localparam int SH_RED  = 1;
	localparam int SH_NGRN = 2;

	// Status byte bits and blanking byte
	localparam int ST_BUSY_BIT  = 7;
	localparam int ST_ACK_BIT   = 6;
	localparam int ST_PAPER_BIT = 5;
	localparam int ST_ERROR_BIT = 3;
	localparam logic [7:0] BLANK_BYTE = 8'hFF;

	typedef struct packed {
		logic             operation;
		logic [5:0]       pixel_index;
		logic [PIX_W-1:0] pixel_value;
		logic [7:0]       status_byte;
	} scan_in_t;

	typedef struct packed {
		logic       port_select;
		logic [7:0] port_value;
		logic       last_write;
	} scan_out_t;

	// Controller to datapath
	typedef struct packed {
		logic               wr_pix;
		logic               start;
		logic               emit;
		logic [KIND_W-1:0]  kind;
		logic               rd_en;
		logic [COORD_W-1:0] rd_col;
		logic               finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

/* hw/rtl/lmrrs_dp.sv */
// Datapath: frame store, rotation addressing, control shadow and output register.
`include "led_matrix_rotating_row_scanner_macros.svh"

module lmrrs_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lmrrs_pkg::dp_cmd_t    cmd,
	output lmrrs_pkg::dp_status_t status,
	input  lmrrs_pkg::scan_in_t   item,
	output logic                  port_valid,
	input  logic                  port_ready,
	output lmrrs_pkg::scan_out_t  port_wr
);
	import lmrrs_pkg::*;

	logic [PIX_W-1:0]   frame_q [NUM_PIX];
	logic [NUM_PIX-1:0] valid_q;
	logic [PIX_W-1:0]   rd_s1;
	logic               rd_vld_s1;
	logic [COORD_W-1:0] row_q;
	logic [1:0]         orient_q;
	logic [2:0]         shadow_q;
	logic [7:0]         status_q;
	logic               out_valid_q;
	scan_out_t          out_q;

	logic               wr_hit;
	logic [IDX_W-1:0]   wr_addr;
	logic [COORD_W-1:0] lo_coord, hi_coord;
	logic [IDX_W-1:0]   rd_addr;
	logic [PIX_W-1:0]   pix;
	logic [2:0]         shadow_nx;
	logic [7:0]         sel_byte;
	scan_out_t          out_nx;
	logic [1:0]         orient_nx;
	logic               busy, ack, err, pout;

	// Pixel writes outside the matrix are dropped
	assign wr_hit  = cmd.wr_pix && (32'(item.pixel_index) < NUM_PIX);
	assign wr_addr = IDX_W'(item.pixel_index);

	// Frame store write port
	always_ff @(posedge clk) begin
		if (wr_hit) begin
			frame_q[wr_addr] <= item.pixel_value;
		end
	end

	// Written flags, cleared at reset so unwritten pixels read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_hit) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Rotation: split the read position into low and high coordinates
	always_comb begin
		case (orient_q)
			2'd0: begin
				lo_coord = row_q;
				hi_coord = cmd.rd_col;
			end
			2'd1: begin
				lo_coord = COORD_LAST - cmd.rd_col;
				hi_coord = row_q;
			end
			2'd2: begin
				lo_coord = COORD_LAST - row_q;
				hi_coord = COORD_LAST - cmd.rd_col;
			end
			default: begin
				lo_coord = cmd.rd_col;
				hi_coord = COORD_LAST - row_q;
			end
		endcase
	end

	assign rd_addr = IDX_W'(lo_coord) + IDX_W'(hi_coord) * SIDE_IDX;

	// Registered read port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1     <= frame_q[rd_addr];
			rd_vld_s1 <= valid_q[rd_addr];
		end
	end

	assign pix = rd_vld_s1 ? rd_s1 : '0;

	// Active-low row select; rows beyond the byte leave it all high
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sel_byte[i] = !(32'(row_q) == i);
		end
	end

	// Next shadow and the port write for this step
	always_comb begin
		shadow_nx = shadow_q;
		out_nx    = '{port_select: PORT_DATA, port_value: BLANK_BYTE, last_write: 1'b0};
		case (cmd.kind)
			EMIT_BLANK: begin
				out_nx.port_select = PORT_DATA;
				out_nx.port_value  = BLANK_BYTE;
			end
			EMIT_DATA: begin
				shadow_nx[SH_RED]  = pix[1];
				shadow_nx[SH_NGRN] = !pix[0];
				out_nx.port_select = PORT_CTRL;
				out_nx.port_value  = {5'd0, shadow_nx};
			end
			EMIT_CLKLO: begin
				shadow_nx[SH_CLK]  = 1'b0;
				out_nx.port_select = PORT_CTRL;
				out_nx.port_value  = {5'd0, shadow_nx};
			end
			EMIT_CLKHI: begin
				shadow_nx[SH_CLK]  = 1'b1;
				out_nx.port_select = PORT_CTRL;
				out_nx.port_value  = {5'd0, shadow_nx};
			end
			EMIT_SEL: begin
				out_nx.port_select = PORT_DATA;
				out_nx.port_value  = sel_byte;
				out_nx.last_write  = 1'b1;
			end
			default: begin
				out_nx = '{port_select: PORT_DATA, port_value: BLANK_BYTE, last_write: 1'b0};
			end
		endcase
	end

	// Tilt decode: later pairs take priority
	assign busy = status_q[ST_BUSY_BIT];
	assign ack  = !status_q[ST_ACK_BIT];
	assign err  = !status_q[ST_ERROR_BIT];
	assign pout = !status_q[ST_PAPER_BIT];

	always_comb begin
		orient_nx = orient_q;
		if (pout && ack) orient_nx = 2'd0;
		if (busy && ack) orient_nx = 2'd1;
		if (busy && err) orient_nx = 2'd2;
		if (pout && err) orient_nx = 2'd3;
	end

	// Scan state: row, rotation and shadow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			orient_q <= '0;
			shadow_q <= '0;
		end else begin
			if (cmd.emit) begin
				shadow_q <= shadow_nx;
			end
			if (cmd.finish) begin
				row_q    <= (row_q == COORD_LAST) ? '0 : row_q + 1'b1;
				orient_q <= orient_nx;
			end
		end
	end

	// Status byte sampled when the tick is taken
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			status_q <= item.status_byte;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (port_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q <= out_nx;
		end
	end

	assign status.out_free = !out_valid_q || port_ready;
	assign port_valid      = out_valid_q;
	assign port_wr         = out_q;

	`LMRRS_ASSERT(a_last_on_data, out_valid_q && out_q.last_write |-> out_q.port_select == PORT_DATA, "last write not on data port")
	`LMRRS_ASSERT(a_row_moves, cmd.finish |=> row_q != $past(row_q), "row counter did not advance")
	`LMRRS_ASSERT(a_clk_high, cmd.emit && cmd.kind == EMIT_CLKHI |=> shadow_q[SH_CLK], "clock bit not set after clock high")

endmodule

/* hw/rtl/lmrrs_ctrl.sv */
// Controller: sequences the port writes of a scan tick and takes pixel writes.
`include "led_matrix_rotating_row_scanner_macros.svh"

module lmrrs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_op,
	output logic                  item_ready,
	input  lmrrs_pkg::dp_status_t status,
	output lmrrs_pkg::dp_cmd_t    cmd
);
	import lmrrs_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BLANK = 3'd1;
	localparam logic [2:0] ST_DATA  = 3'd2;
	localparam logic [2:0] ST_CLKLO = 3'd3;
	localparam logic [2:0] ST_CLKHI = 3'd4;
	localparam logic [2:0] ST_SEL   = 3'd5;

	logic [2:0]         state_q, state_nx;
	logic [COORD_W-1:0] col_q, col_nx;

	assign item_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		col_nx   = col_q;
		cmd      = '0;
		cmd.rd_col = col_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item_op == OP_SCAN) begin
						cmd.start = 1'b1;
						state_nx  = ST_BLANK;
					end else begin
						cmd.wr_pix = 1'b1;
					end
				end
			end
			ST_BLANK: begin
				cmd.kind = EMIT_BLANK;
				if (status.out_free) begin
					cmd.emit   = 1'b1;
					cmd.rd_en  = 1'b1;
					cmd.rd_col = '0;
					col_nx     = '0;
					state_nx   = ST_DATA;
				end
			end
			ST_DATA: begin
				cmd.kind = EMIT_DATA;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_nx = ST_CLKLO;
				end
			end
			ST_CLKLO: begin
				cmd.kind = EMIT_CLKLO;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_nx = ST_CLKHI;
				end
			end
			ST_CLKHI: begin
				cmd.kind = EMIT_CLKHI;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (col_q == COORD_LAST) begin
						state_nx = ST_SEL;
					end else begin
						// prefetch the next column's pixel
						cmd.rd_en  = 1'b1;
						cmd.rd_col = col_q + 1'b1;
						col_nx     = col_q + 1'b1;
						state_nx   = ST_DATA;
					end
				end
			end
			ST_SEL: begin
				cmd.kind = EMIT_SEL;
				if (status.out_free) begin
					cmd.emit   = 1'b1;
					cmd.finish = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
		end else begin
			state_q <= state_nx;
			col_q   <= col_nx;
		end
	end

	`LMRRS_ASSERT(a_sel_after_last_col, state_q == ST_SEL |-> col_q == COORD_LAST, "row select before last column")
	`LMRRS_ASSERT(a_no_emit_idle, item_ready |-> !cmd.emit, "port write issued while idle")
	`LMRRS_ASSERT(a_read_then_data, cmd.rd_en |=> state_q == ST_DATA, "pixel read not followed by data write")

endmodule

/* hw/rtl/led_matrix_rotating_row_scanner.sv */
// Top level of the rotating row scanner for a two-colour LED matrix.
//
//  channel  | direction | payload    | transaction
//  item     | in        | scan_in_t  | one pixel write or one scan tick
//  port_wr  | out       | scan_out_t | one write to the data or control port
//
// A pixel write gives no port write.
// A scan tick gives 26 port writes after the accept, one a cycle through the single
// output register while the output is not stalled; no item is taken mid-tick.
// After reset the frame store reads as all zero with no clearing pass.

module led_matrix_rotating_row_scanner (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  lmrrs_pkg::scan_in_t  item,
	output logic                 port_valid,
	input  logic                 port_ready,
	output lmrrs_pkg::scan_out_t port_wr
);
	import lmrrs_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	lmrrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.operation),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	lmrrs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.item       (item),
		.port_valid (port_valid),
		.port_ready (port_ready),
		.port_wr    (port_wr)
	);

endmodule
